>>> rtl/core/mwpo_pkg.sv
// shared types, constants and helper functions for the phase oscillator
// no dependencies; used by every module under rtl/core
package mwpo_pkg;

  typedef enum logic [1:0] {
    WAVE_SAW      = 2'd0,
    WAVE_PULSE    = 2'd1,
    WAVE_SINE     = 2'd2,
    WAVE_TRIANGLE = 2'd3
  } wave_t;

  // configuration register indexes
  localparam logic [1:0] REG_WAVEFORM        = 2'd0;
  localparam logic [1:0] REG_PHASE_SCALE     = 2'd1;
  localparam logic [1:0] REG_START_FREQUENCY = 2'd2;

  localparam int CFG_DATA_W = 40;

  localparam logic [39:0]        PHASE_SCALE_RESET = 40'd93824992237;
  localparam logic signed [23:0] START_FREQ_RESET  = 24'sd112640;

  localparam int QUEUE_DEPTH = 4;
  localparam int SCALE_SPLIT = 20;

  localparam logic [63:0] TWO_PI_Q30 = 64'd6746518852;
  localparam logic [63:0] POLY_ONE   = 64'd1 << 30;

  // one classified request on its way to the back end
  typedef struct packed {
    logic signed [23:0] frequency;
    logic signed [31:0] threshold;
    logic               reset_phase;
  } item_t;

  typedef struct packed {
    wave_t       waveform;
    logic [39:0] phase_scale;
  } cfg_t;

  function automatic logic signed [17:0] sat_sample(input logic signed [35:0] v);
    logic signed [17:0] r;
    if (v > 36'sd131071) begin
      r = 18'sd131071;
    end else if (v < -36'sd131072) begin
      r = -18'sd131072;
    end else begin
      r = v[17:0];
    end
    return r;
  endfunction

  // sin(2*pi*r / 2^tbits) in Q2.15 for r up to a quarter turn, taylor form
  function automatic logic [16:0] quarter_sine(input logic [15:0] r, input int tbits);
    logic [63:0] th;
    logic [63:0] th2;
    logic [63:0] t;
    logic [63:0] res;
    th  = (64'(r) * TWO_PI_Q30) >> tbits;
    th2 = (th * th) >> 30;
    t   = POLY_ONE;
    t   = POLY_ONE - ((th2 * t) >> 30) / 64'd72;
    t   = POLY_ONE - ((th2 * t) >> 30) / 64'd42;
    t   = POLY_ONE - ((th2 * t) >> 30) / 64'd20;
    t   = POLY_ONE - ((th2 * t) >> 30) / 64'd6;
    res = (((th * t) >> 30) + 64'd16384) >> 15;
    return res[16:0];
  endfunction

endpackage

>>> rtl/core/mwpo_front.sv
// front end: takes input requests, resolves held frequency and pulse threshold
// depends on mwpo_pkg
module mwpo_front #(
  parameter int PHASE_FRACTION_BITS = 30
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [23:0]       frequency,
  input  logic                     frequency_present,
  input  logic signed [31:0]       pulse_width,
  input  logic                     pulse_width_present,
  input  logic                     reset_phase,
  input  logic                     start_load,
  input  logic signed [23:0]       start_value,
  input  logic                     queue_full,
  output logic                     push,
  output mwpo_pkg::item_t          item
);

  localparam int PW_SHIFT = 30 - PHASE_FRACTION_BITS;
  localparam logic signed [31:0] HALF = 32'(64'd1 << (PHASE_FRACTION_BITS - 1));

  logic signed [23:0] held_frequency;

  assign in_stall = queue_full;
  assign push     = in_valid && !queue_full;

  always_comb begin
    item.frequency   = frequency_present ? frequency : held_frequency;
    item.threshold   = pulse_width_present ? (pulse_width >>> PW_SHIFT) : HALF;
    item.reset_phase = reset_phase;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_frequency <= mwpo_pkg::START_FREQ_RESET;
    end else if (start_load) begin
      held_frequency <= start_value;
    end else if (push && frequency_present) begin
      held_frequency <= frequency;
    end
  end

endmodule

>>> rtl/core/mwpo_queue.sv
// small register queue between front and back end
// depends on mwpo_pkg for the item type
module mwpo_queue #(
  parameter int DEPTH = 4
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mwpo_pkg::item_t item_in,
  output logic            full,
  input  logic            pop,
  output logic            item_valid,
  output mwpo_pkg::item_t item_out
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

  mwpo_pkg::item_t  entries [DEPTH];
  logic [PTR_W-1:0] head;
  logic [PTR_W-1:0] tail;
  logic [CNT_W-1:0] count;

  assign full       = (count == CNT_W'(DEPTH));
  assign item_valid = (count != '0);
  assign item_out   = entries[head];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[tail] <= item_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head  <= '0;
      tail  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        tail <= (tail == LAST) ? '0 : tail + 1'b1;
      end
      if (pop) begin
        head <= (head == LAST) ? '0 : head + 1'b1;
      end
      case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(DEPTH)) else $error("queue count above depth");
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && full)) else $error("push into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && !item_valid)) else $error("pop from empty queue");

endmodule

>>> rtl/core/mwpo_back.sv
// back end: increment multiply, phase accumulator, waveform shaping, output register
// depends on mwpo_pkg
module mwpo_back #(
  parameter int SINE_TABLE_BITS     = 10,
  parameter int PHASE_FRACTION_BITS = 30
) (
  input  logic                clk,
  input  logic                rst,
  input  mwpo_pkg::cfg_t      cfg,
  input  logic                item_valid,
  input  mwpo_pkg::item_t     item,
  output logic                item_pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic signed [17:0]  sample
);

  localparam int SPLIT     = mwpo_pkg::SCALE_SPLIT;
  localparam int PROD_W    = 24 + SPLIT + 1;
  localparam int INC_SHIFT = 60 - PHASE_FRACTION_BITS;
  localparam int OUT_SHIFT = PHASE_FRACTION_BITS - 15;
  localparam int QUARTER   = 1 << (SINE_TABLE_BITS - 2);
  localparam int RIDX_W    = SINE_TABLE_BITS - 1;
  localparam logic [31:0] ONE     = 32'(64'd1 << PHASE_FRACTION_BITS);
  localparam logic [31:0] TWO_ONE = 32'(64'd2 << PHASE_FRACTION_BITS);
  localparam logic signed [35:0] ONE_W  = 36'(64'd1 << PHASE_FRACTION_BITS);
  localparam logic signed [35:0] HALF_W = 36'(64'd1 << (PHASE_FRACTION_BITS - 1));
  localparam logic signed [35:0] QTR_W  = 36'(64'd1 << (PHASE_FRACTION_BITS - 2));

  logic advance;

  // stage 1: split multiply
  logic                      v1;
  logic signed [PROD_W-1:0]  s1_lo;
  logic signed [PROD_W-1:0]  s1_hi;
  logic                      s1_rst;
  logic signed [31:0]        s1_thr;

  // stage 2: increment
  logic                      v2;
  logic [31:0]               s2_inc;
  logic                      s2_rst;
  logic signed [31:0]        s2_thr;

  // stage 3 state
  logic [31:0]               phase;
  logic [31:0]               phase_next;
  logic signed [17:0]        last_output;
  logic signed [17:0]        result;

  logic signed [PROD_W-1:0]  p_lo;
  logic signed [PROD_W-1:0]  p_hi;
  logic signed [63:0]        prod;
  logic signed [63:0]        prod_sh;

  assign advance  = !out_valid || !out_stall;
  assign item_pop = item_valid && advance;

  assign p_lo = $signed(item.frequency) * $signed({1'b0, cfg.phase_scale[SPLIT-1:0]});
  assign p_hi = $signed(item.frequency) * $signed({1'b0, cfg.phase_scale[39:SPLIT]});

  assign prod    = (64'(s1_hi) <<< SPLIT) + 64'(s1_lo);
  assign prod_sh = prod >>> INC_SHIFT;

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_lo  <= p_lo;
      s1_hi  <= p_hi;
      s1_rst <= item.reset_phase;
      s1_thr <= item.threshold;
      s2_inc <= prod_sh[31:0];
      s2_rst <= s1_rst;
      s2_thr <= s1_thr;
    end
  end

  // quarter-wave sine table, mirrored by quadrant
  logic [16:0] quarter_rom [QUARTER+1];

  for (genvar k = 0; k <= QUARTER; k++) begin : g_rom
    assign quarter_rom[k] = mwpo_pkg::quarter_sine(16'(k), SINE_TABLE_BITS);
  end

  logic [31:0]                 p0;
  logic [31:0]                 wrapped;
  logic [31:0]                 stepped;
  logic [31:0]                 saw_next;
  logic signed [35:0]          p0_w;
  logic signed [35:0]          st_w;
  logic signed [35:0]          tri_v;
  logic [SINE_TABLE_BITS-1:0]  sidx;
  logic [RIDX_W-1:0]           ridx;
  logic [16:0]                 smag;
  logic signed [17:0]          sine_out;

  always_comb begin
    p0       = s2_rst ? '0 : phase;
    wrapped  = ($signed(p0) >= $signed(ONE)) ? p0 - ONE : p0;
    stepped  = wrapped + s2_inc;
    saw_next = (($signed(p0) >= $signed(ONE)) ? p0 - TWO_ONE : p0) + (s2_inc << 1);
    p0_w     = 36'($signed(p0));
    st_w     = 36'($signed(stepped));

    if (st_w <= HALF_W) begin
      tri_v = (st_w - QTR_W) <<< 2;
    end else begin
      tri_v = ((ONE_W - st_w) - QTR_W) <<< 2;
    end

    sidx = p0[PHASE_FRACTION_BITS-1 -: SINE_TABLE_BITS];
    if (sidx[SINE_TABLE_BITS-2]) begin
      ridx = RIDX_W'(QUARTER) - {1'b0, sidx[SINE_TABLE_BITS-3:0]};
    end else begin
      ridx = {1'b0, sidx[SINE_TABLE_BITS-3:0]};
    end
    smag     = quarter_rom[ridx];
    sine_out = sidx[SINE_TABLE_BITS-1] ? -$signed({1'b0, smag}) : $signed({1'b0, smag});

    case (cfg.waveform)
      mwpo_pkg::WAVE_SAW: begin
        result     = mwpo_pkg::sat_sample(p0_w >>> OUT_SHIFT);
        phase_next = saw_next;
      end
      mwpo_pkg::WAVE_PULSE: begin
        if ($signed(stepped) < s2_thr) begin
          result = -18'sd32768;
        end else if ($signed(stepped) > s2_thr) begin
          result = 18'sd32768;
        end else begin
          result = last_output;
        end
        phase_next = stepped;
      end
      mwpo_pkg::WAVE_SINE: begin
        result     = sine_out;
        phase_next = stepped;
      end
      default: begin
        result     = mwpo_pkg::sat_sample(tri_v >>> OUT_SHIFT);
        phase_next = stepped;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (advance && v2) begin
      sample <= result;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1          <= 1'b0;
      v2          <= 1'b0;
      out_valid   <= 1'b0;
      phase       <= '0;
      last_output <= '0;
    end else if (advance) begin
      v1        <= item_pop;
      v2        <= v1;
      out_valid <= v2;
      if (v2) begin
        phase       <= phase_next;
        last_output <= result;
      end
    end
  end

  a_sample_tracks_last: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> sample == last_output) else $error("sample differs from held output");
  a_phase_holds: assert property (@(posedge clk) disable iff (rst)
    !(advance && v2) |=> $stable(phase)) else $error("phase moved without a request");
  a_stall_freezes: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |=> $stable(v2) && $stable(v1)) else $error("pipe moved under stall");

endmodule

>>> rtl/core/multi_waveform_phase_oscillator_unit.sv
// top level of the multi-waveform phase accumulator oscillator
// depends on mwpo_pkg, mwpo_front, mwpo_queue, mwpo_back
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+-----------------------------------------
//  in       | sink      | in_valid/in_stall | frequency, frequency_present,
//           |           |                   | pulse_width, pulse_width_present, reset_phase
//  out      | source    | out_valid/out_stall | sample
//  cfg      | sink      | cfg_write         | cfg_index, cfg_data
//
// one request per cycle sustained while the output is not stalled; a result passes the queue,
// the multiply stage and the increment stage before it leaves the output register
// the phase accumulator add in the last stage is the loop that sets the rate
// reset clears the pipe, the queue, the phase and the held output, and loads
// the configuration and held frequency with their defaults
// a stalled output freezes the back end; the four-entry queue keeps taking
// requests until it fills, then in_stall rises
module multi_waveform_phase_oscillator_unit #(
  parameter int SINE_TABLE_BITS     = 10,
  parameter int PHASE_FRACTION_BITS = 30
) (
  input  logic                                clk,
  input  logic                                rst,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [23:0]                  frequency,
  input  logic                                frequency_present,
  input  logic signed [31:0]                  pulse_width,
  input  logic                                pulse_width_present,
  input  logic                                reset_phase,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [17:0]                  sample,
  // configuration writes
  input  logic                                cfg_write,
  input  logic [1:0]                          cfg_index,
  input  logic [mwpo_pkg::CFG_DATA_W-1:0]     cfg_data
);

  // configuration registers
  mwpo_pkg::wave_t    waveform;
  logic [39:0]        phase_scale;
  logic signed [23:0] start_frequency;
  mwpo_pkg::cfg_t     cfg;

  logic               start_load;

  // front to queue to back
  logic               push;
  logic               queue_full;
  mwpo_pkg::item_t    front_item;
  logic               pop;
  logic               queued_valid;
  mwpo_pkg::item_t    queued_item;

  assign start_load = cfg_write && (cfg_index == mwpo_pkg::REG_START_FREQUENCY);

  always_ff @(posedge clk) begin
    if (rst) begin
      waveform        <= mwpo_pkg::WAVE_SAW;
      phase_scale     <= mwpo_pkg::PHASE_SCALE_RESET;
      start_frequency <= mwpo_pkg::START_FREQ_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        mwpo_pkg::REG_WAVEFORM:        waveform        <= mwpo_pkg::wave_t'(cfg_data[1:0]);
        mwpo_pkg::REG_PHASE_SCALE:     phase_scale     <= cfg_data[39:0];
        mwpo_pkg::REG_START_FREQUENCY: start_frequency <= $signed(cfg_data[23:0]);
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  always_comb begin
    cfg.waveform    = waveform;
    cfg.phase_scale = phase_scale;
  end

  // held frequency loads together with the start frequency register
  mwpo_front #(
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
  ) u_front (
    .clk                 (clk),
    .rst                 (rst),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .frequency           (frequency),
    .frequency_present   (frequency_present),
    .pulse_width         (pulse_width),
    .pulse_width_present (pulse_width_present),
    .reset_phase         (reset_phase),
    .start_load          (start_load),
    .start_value         ($signed(cfg_data[23:0])),
    .queue_full          (queue_full),
    .push                (push),
    .item                (front_item)
  );

  mwpo_queue #(
    .DEPTH (mwpo_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .item_in    (front_item),
    .full       (queue_full),
    .pop        (pop),
    .item_valid (queued_valid),
    .item_out   (queued_item)
  );

  mwpo_back #(
    .SINE_TABLE_BITS     (SINE_TABLE_BITS),
    .PHASE_FRACTION_BITS (PHASE_FRACTION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg        (cfg),
    .item_valid (queued_valid),
    .item       (queued_item),
    .item_pop   (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .sample     (sample)
  );

  // start_frequency keeps a copy of each start frequency write; held frequency reloads from cfg_data
  a_start_copy: assert property (@(posedge clk) disable iff (rst)
    start_load |=> start_frequency == $past($signed(cfg_data[23:0])))
    else $error("start frequency not captured");

endmodule
